FILE: sv/rsn_pkg.sv
// Shared types and constants for the range surface normal stream.
// Holds register indexes, reset values and the fixed field widths.
// No dependencies; every other file imports this package.
package rsn_pkg;

    // Width of the configuration index and data fields.
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 11;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FG_THRESHOLD = 2'd0,
        CFG_IMAGE_WIDTH  = 2'd1
    } t_cfg_idx;

    // Register reset values.
    localparam logic [7:0]       FG_THRESHOLD_RST = 8'd125;
    localparam logic [CFG_W-1:0] IMAGE_WIDTH_RST  = 11'd128;

    // Row counter width and its saturation value.
    localparam int              ROW_W   = 10;
    localparam logic [ROW_W-1:0] ROW_MAX = 10'd1023;

    // Width of each normal component.
    localparam int OUT_W = 36;

endpackage

FILE: sv/rsn_front.sv
// Front stage: configuration registers, raster row/column counters,
// line buffer addressing and the left-neighbor history. Uses rsn_pkg.
module rsn_front
    import rsn_pkg::*;
#(
    parameter int MAX_WIDTH     = 1024,
    parameter int NEIGHBOR_DIST = 3,
    parameter int COORD_BITS    = 16,
    localparam int AW = $clog2(NEIGHBOR_DIST * MAX_WIDTH),
    localparam int PW = 3 * COORD_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Configuration writes.
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_W-1:0]             i_cfg_data,
    // Incoming pixel transaction.
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_frame_start,
    input  logic [7:0]                   i_range_value,
    input  logic signed [COORD_BITS-1:0] i_point_x,
    input  logic signed [COORD_BITS-1:0] i_point_y,
    input  logic signed [COORD_BITS-1:0] i_point_z,
    // Toward the line buffer stage.
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [AW-1:0]                o_addr,
    output logic [PW-1:0]                o_p0,
    output logic [PW-1:0]                o_left,
    output logic                         o_calc
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W = (WW > CFG_W) ? WW : CFG_W;
    localparam int SW    = (NEIGHBOR_DIST > 1) ? $clog2(NEIGHBOR_DIST) : 1;

    logic [7:0]       r_fg_thr;
    logic [CFG_W-1:0] r_width;
    logic [CW-1:0]    r_col;
    logic [ROW_W-1:0] r_row;
    logic [SW-1:0]    r_slot;
    logic [PW-1:0]    r_hist [NEIGHBOR_DIST];

    logic             r_valid;
    logic [AW-1:0]    r_addr;
    logic [PW-1:0]    r_p0;
    logic [PW-1:0]    r_left;
    logic             r_calc;

    logic [CMP_W-1:0] w_eff;
    logic [CW-1:0]    col_a, col_b, n_col;
    logic [ROW_W-1:0] row_a, row_b, n_row;
    logic [SW-1:0]    slot_a, slot_b, n_slot;
    logic [CMP_W-1:0] col_c;
    logic             accept;
    logic             border_ok;
    logic [PW-1:0]    p0;

    function automatic logic [ROW_W-1:0] row_inc(input logic [ROW_W-1:0] r);
        return (r == ROW_MAX) ? r : r + 1'b1;
    endfunction

    function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
        return (s == SW'(NEIGHBOR_DIST - 1)) ? '0 : s + 1'b1;
    endfunction

    assign accept  = i_valid && o_ready;
    assign o_ready = !r_valid || i_ready;
    assign p0      = {i_point_z, i_point_y, i_point_x};

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg_thr <= FG_THRESHOLD_RST;
            r_width  <= IMAGE_WIDTH_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_FG_THRESHOLD: r_fg_thr <= i_cfg_data[7:0];
                CFG_IMAGE_WIDTH:  r_width  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Effective row width: clamp to the buffer size, and treat zero as one.
    always_comb begin
        w_eff = CMP_W'(r_width);
        if (CMP_W'(r_width) > CMP_W'(MAX_WIDTH)) begin
            w_eff = CMP_W'(MAX_WIDTH);
        end else if (r_width == '0) begin
            w_eff = CMP_W'(1);
        end
    end

    // Position of this pixel and the counter values after it.
    always_comb begin
        col_a  = i_frame_start ? '0 : r_col;
        row_a  = i_frame_start ? '0 : r_row;
        slot_a = i_frame_start ? '0 : r_slot;

        // A width lowered mid-row starts a new row before the pixel.
        if (CMP_W'(col_a) >= w_eff) begin
            col_b  = '0;
            row_b  = row_inc(row_a);
            slot_b = slot_inc(slot_a);
        end else begin
            col_b  = col_a;
            row_b  = row_a;
            slot_b = slot_a;
        end

        col_c = CMP_W'(col_b) + 1'b1;
        if (col_c >= w_eff) begin
            n_col  = '0;
            n_row  = row_inc(row_b);
            n_slot = slot_inc(slot_b);
        end else begin
            n_col  = col_c[CW-1:0];
            n_row  = row_b;
            n_slot = slot_b;
        end

        border_ok = (row_b >= ROW_W'(NEIGHBOR_DIST)) &&
                    (CMP_W'(col_b) >= CMP_W'(NEIGHBOR_DIST));
    end

    // Raster counters advance once per accepted transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_slot <= '0;
        end else if (accept) begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_slot <= n_slot;
        end
    end

    // The last few points of the stream; the oldest is the left neighbor
    // whenever the border test passes.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_hist[0] <= p0;
            for (int k = 1; k < NEIGHBOR_DIST; k++) begin
                r_hist[k] <= r_hist[k-1];
            end
        end
    end

    // Stage valid bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_addr <= AW'(slot_b) * AW'(MAX_WIDTH) + AW'(col_b);
            r_p0   <= p0;
            r_left <= r_hist[NEIGHBOR_DIST-1];
            r_calc <= (i_range_value <= r_fg_thr) && border_ok;
        end
    end

    assign o_valid = r_valid;
    assign o_addr  = r_addr;
    assign o_p0    = r_p0;
    assign o_left  = r_left;
    assign o_calc  = r_calc;

endmodule

FILE: sv/rsn_line_mem.sv
// Line buffer stage: reads the point one neighbor distance above and
// writes the current point at the same address. Uses rsn_pkg.
module rsn_line_mem
    import rsn_pkg::*;
#(
    parameter int MAX_WIDTH     = 1024,
    parameter int NEIGHBOR_DIST = 3,
    parameter int COORD_BITS    = 16,
    localparam int AW = $clog2(NEIGHBOR_DIST * MAX_WIDTH),
    localparam int PW = 3 * COORD_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [AW-1:0] i_addr,
    input  logic [PW-1:0] i_p0,
    input  logic [PW-1:0] i_left,
    input  logic          i_calc,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [PW-1:0] o_up,
    output logic [PW-1:0] o_p0,
    output logic [PW-1:0] o_left,
    output logic          o_calc
);

    localparam int DEPTH = NEIGHBOR_DIST * MAX_WIDTH;

    logic [PW-1:0] r_mem [DEPTH];
    logic          r_valid;
    logic [PW-1:0] r_up;
    logic [PW-1:0] r_p0;
    logic [PW-1:0] r_left;
    logic          r_calc;
    logic          accept;

    assign accept  = i_valid && o_ready;
    assign o_ready = !r_valid || i_ready;

    // Read-first access: the old point is read before this one replaces it.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_up         <= r_mem[i_addr];
            r_mem[i_addr] <= i_p0;
        end
    end

    // Payload carried alongside the read data.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_p0   <= i_p0;
            r_left <= i_left;
            r_calc <= i_calc;
        end
    end

    // Stage valid bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    assign o_valid = r_valid;
    assign o_up    = r_up;
    assign o_p0    = r_p0;
    assign o_left  = r_left;
    assign o_calc  = r_calc;

endmodule

FILE: sv/rsn_cross.sv
// Cross product pipeline: difference vectors, six products, then the
// combined and saturated normal components. Uses rsn_pkg.
module rsn_cross
    import rsn_pkg::*;
#(
    parameter int COORD_BITS = 16,
    localparam int PW = 3 * COORD_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [PW-1:0]           i_up,
    input  logic [PW-1:0]           i_p0,
    input  logic [PW-1:0]           i_left,
    input  logic                    i_calc,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic                    o_normal_valid,
    output logic signed [OUT_W-1:0] o_normal_x,
    output logic signed [OUT_W-1:0] o_normal_y,
    output logic signed [OUT_W-1:0] o_normal_z
);

    localparam int C   = COORD_BITS;
    localparam int DW  = C + 1;
    localparam int PRW = 2 * DW;
    localparam int SUW = PRW + 1;
    localparam int EW  = (SUW > OUT_W) ? SUW : OUT_W;
    localparam logic signed [EW-1:0] SAT_HI =
        {{(EW - OUT_W + 1){1'b0}}, {(OUT_W - 1){1'b1}}};
    localparam logic signed [EW-1:0] SAT_LO = ~SAT_HI;

    logic signed [C-1:0]   up_x, up_y, up_z, p0_x, p0_y, p0_z, lf_x, lf_y, lf_z;

    // Stage valid bits and the ready chain between stages.
    logic r_v3, r_v4, r_v5;
    logic rdy3, rdy4, rdy5;
    logic acc3, acc4, acc5;

    logic signed [DW-1:0]    r_ax, r_ay, r_az, r_bx, r_by, r_bz;
    logic                    r_calc3, r_calc4, r_calc5;
    logic signed [PRW-1:0]   r_m [6];
    logic signed [SUW-1:0]   n_x, n_y, n_z;
    logic signed [OUT_W-1:0] r_nx, r_ny, r_nz;

    function automatic logic signed [OUT_W-1:0] sat(input logic signed [SUW-1:0] v);
        logic signed [EW-1:0] ve;
        ve = EW'(v);
        if (ve > SAT_HI) begin
            return OUT_W'(SAT_HI);
        end else if (ve < SAT_LO) begin
            return OUT_W'(SAT_LO);
        end
        return OUT_W'(ve);
    endfunction

    assign {up_z, up_y, up_x} = i_up;
    assign {p0_z, p0_y, p0_x} = i_p0;
    assign {lf_z, lf_y, lf_x} = i_left;

    assign rdy5    = !r_v5 || i_ready;
    assign rdy4    = !r_v4 || rdy5;
    assign rdy3    = !r_v3 || rdy4;
    assign o_ready = rdy3;
    assign acc3    = i_valid && rdy3;
    assign acc4    = r_v3 && rdy4;
    assign acc5    = r_v4 && rdy5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (acc3) begin
                r_v3 <= 1'b1;
            end else if (rdy4) begin
                r_v3 <= 1'b0;
            end
            if (acc4) begin
                r_v4 <= 1'b1;
            end else if (rdy5) begin
                r_v4 <= 1'b0;
            end
            if (acc5) begin
                r_v5 <= 1'b1;
            end else if (i_ready) begin
                r_v5 <= 1'b0;
            end
        end
    end

    // Difference vectors: a points up, b points left.
    always_ff @(posedge i_clk) begin
        if (acc3) begin
            r_ax    <= DW'(up_x) - DW'(p0_x);
            r_ay    <= DW'(up_y) - DW'(p0_y);
            r_az    <= DW'(up_z) - DW'(p0_z);
            r_bx    <= DW'(lf_x) - DW'(p0_x);
            r_by    <= DW'(lf_y) - DW'(p0_y);
            r_bz    <= DW'(lf_z) - DW'(p0_z);
            r_calc3 <= i_calc;
        end
    end

    // The six partial products of the cross product.
    always_ff @(posedge i_clk) begin
        if (acc4) begin
            r_m[0]  <= PRW'(r_ay) * PRW'(r_bz);
            r_m[1]  <= PRW'(r_az) * PRW'(r_by);
            r_m[2]  <= PRW'(r_az) * PRW'(r_bx);
            r_m[3]  <= PRW'(r_ax) * PRW'(r_bz);
            r_m[4]  <= PRW'(r_ax) * PRW'(r_by);
            r_m[5]  <= PRW'(r_ay) * PRW'(r_bx);
            r_calc4 <= r_calc3;
        end
    end

    // Combine, saturate and zero the normal for pixels that get none.
    always_comb begin
        n_x = SUW'(r_m[0]) - SUW'(r_m[1]);
        n_y = SUW'(r_m[2]) - SUW'(r_m[3]);
        n_z = SUW'(r_m[4]) - SUW'(r_m[5]);
    end

    always_ff @(posedge i_clk) begin
        if (acc5) begin
            r_calc5 <= r_calc4;
            r_nx    <= r_calc4 ? sat(n_x) : '0;
            r_ny    <= r_calc4 ? sat(n_y) : '0;
            r_nz    <= r_calc4 ? sat(n_z) : '0;
        end
    end

    assign o_valid        = r_v5;
    assign o_normal_valid = r_calc5;
    assign o_normal_x     = r_nx;
    assign o_normal_y     = r_ny;
    assign o_normal_z     = r_nz;

endmodule

FILE: sv/range_surface_normal_stream.sv
// Range surface normal stream, top level.
//
// Pixels arrive in raster order on the input channel (i_in_valid / o_in_ready),
// each with a frame start flag, a range byte and its signed Q9.6 point. For
// every accepted pixel exactly one result transaction leaves on the output
// channel (o_out_valid / i_out_ready): the cross product of the vectors to the
// point NEIGHBOR_DIST rows above and NEIGHBOR_DIST columns to the left, with
// o_normal_valid high, or an all-zero normal with o_normal_valid low for
// background pixels and pixels near the top or left border.
// The configuration channel (i_cfg_valid / o_cfg_ready, always ready) sets
// the foreground threshold (index 0) and the image width (index 1); write it
// only while no transaction is in flight.
// The design is a five-stage pipeline that accepts one pixel every cycle
// while the receiver keeps up; the line buffer is a single read-first
// memory port used once per pixel.
// A stalled receiver holds every stage in place; input ready drops only when
// all stages are full. Reset (synchronous, active low) clears the counters,
// the stage valid bits and the registers to their defaults; the line buffer
// contents are left as they are and each frame refills them.
module range_surface_normal_stream
    import rsn_pkg::*;
#(
    parameter int MAX_WIDTH     = 1024,
    parameter int NEIGHBOR_DIST = 3,
    parameter int COORD_BITS    = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Configuration write channel.
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_W-1:0]             i_cfg_data,
    // Pixel input channel.
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_frame_start,
    input  logic [7:0]                   i_range_value,
    input  logic signed [COORD_BITS-1:0] i_point_x,
    input  logic signed [COORD_BITS-1:0] i_point_y,
    input  logic signed [COORD_BITS-1:0] i_point_z,
    // Normal output channel.
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_normal_valid,
    output logic signed [OUT_W-1:0]      o_normal_x,
    output logic signed [OUT_W-1:0]      o_normal_y,
    output logic signed [OUT_W-1:0]      o_normal_z
);

    localparam int AW = $clog2(NEIGHBOR_DIST * MAX_WIDTH);
    localparam int PW = 3 * COORD_BITS;

    logic          f_valid, f_ready, f_calc;
    logic [AW-1:0] f_addr;
    logic [PW-1:0] f_p0, f_left;
    logic          m_valid, m_ready, m_calc;
    logic [PW-1:0] m_up, m_p0, m_left;

    // Configuration writes never stall.
    assign o_cfg_ready = 1'b1;

    // Counters, addressing and the left-neighbor history.
    rsn_front #(
        .MAX_WIDTH    (MAX_WIDTH),
        .NEIGHBOR_DIST(NEIGHBOR_DIST),
        .COORD_BITS   (COORD_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_valid && o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_in_valid),
        .o_ready      (o_in_ready),
        .i_frame_start(i_frame_start),
        .i_range_value(i_range_value),
        .i_point_x    (i_point_x),
        .i_point_y    (i_point_y),
        .i_point_z    (i_point_z),
        .o_valid      (f_valid),
        .i_ready      (f_ready),
        .o_addr       (f_addr),
        .o_p0         (f_p0),
        .o_left       (f_left),
        .o_calc       (f_calc)
    );

    // Line buffer holding the last NEIGHBOR_DIST rows of points.
    rsn_line_mem #(
        .MAX_WIDTH    (MAX_WIDTH),
        .NEIGHBOR_DIST(NEIGHBOR_DIST),
        .COORD_BITS   (COORD_BITS)
    ) u_line_mem (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(f_valid),
        .o_ready(f_ready),
        .i_addr (f_addr),
        .i_p0   (f_p0),
        .i_left (f_left),
        .i_calc (f_calc),
        .o_valid(m_valid),
        .i_ready(m_ready),
        .o_up   (m_up),
        .o_p0   (m_p0),
        .o_left (m_left),
        .o_calc (m_calc)
    );

    // Cross product and output register.
    rsn_cross #(
        .COORD_BITS(COORD_BITS)
    ) u_cross (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (m_valid),
        .o_ready       (m_ready),
        .i_up          (m_up),
        .i_p0          (m_p0),
        .i_left        (m_left),
        .i_calc        (m_calc),
        .o_valid       (o_out_valid),
        .i_ready       (i_out_ready),
        .o_normal_valid(o_normal_valid),
        .o_normal_x    (o_normal_x),
        .o_normal_y    (o_normal_y),
        .o_normal_z    (o_normal_z)
    );

endmodule

FILE: dv/tb_range_surface_normal_stream.sv
// Self-checking testbench for range_surface_normal_stream.
// Predicts each normal from its own copy of the line buffer and counters and
// checks every result transaction. Depends on rsn_pkg and the top level only.
module tb_range_surface_normal_stream;
    import rsn_pkg::*;

    localparam int MAX_W        = 1024;
    localparam int NDIST        = 3;
    localparam int COORD_W      = 16;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int CALM_START   = 300;
    localparam int CALM_END     = 700;
    localparam int HOLD_CYCLES  = 150;
    localparam int RANDOM_ITEMS = 880;
    localparam longint OUT_MAX = (longint'(1) << (OUT_W - 1)) - 1;
    localparam longint OUT_MIN = -OUT_MAX - 1;

    typedef struct packed {
        logic                      frame_start;
        logic [7:0]                range_value;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } t_pixel;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } t_point;

    typedef struct packed {
        logic                    valid;
        logic signed [OUT_W-1:0] x;
        logic signed [OUT_W-1:0] y;
        logic signed [OUT_W-1:0] z;
    } t_normal;

    // Clock, reset and the block's inputs, all known from time zero.
    logic                 i_clk     = 1'b0;
    logic                 i_rst_n   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 pix_valid = 1'b0;
    t_pixel               cur_pixel = '0;
    logic                 result_ready = 1'b0;

    logic                    cfg_ready;
    logic                    pix_ready;
    logic                    result_valid;
    logic                    normal_valid;
    logic signed [OUT_W-1:0] normal_x;
    logic signed [OUT_W-1:0] normal_y;
    logic signed [OUT_W-1:0] normal_z;

    // Pending pixels, expected normals and the predictor's state.
    t_pixel     pixel_queue[$];
    t_normal    normals_due[$];
    t_normal    due_normal;
    t_point     line_store[NDIST*MAX_W];
    int         row_cnt   = 0;
    int         col_cnt   = 0;
    int         row_slot  = 0;
    logic [7:0] thr_shadow   = FG_THRESHOLD_RST;
    logic [CFG_W-1:0] width_shadow = IMAGE_WIDTH_RST;

    int queued_cnt    = 0;
    int checked_cnt   = 0;
    int fg_normal_cnt = 0;
    int error_cnt     = 0;
    int cycle_cnt     = 0;
    int hold_left     = 0;
    int holds_done    = 0;

    range_surface_normal_stream #(
        .MAX_WIDTH     (MAX_W),
        .NEIGHBOR_DIST (NDIST),
        .COORD_BITS    (COORD_W)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (pix_valid),
        .o_in_ready     (pix_ready),
        .i_frame_start  (cur_pixel.frame_start),
        .i_range_value  (cur_pixel.range_value),
        .i_point_x      (cur_pixel.x),
        .i_point_y      (cur_pixel.y),
        .i_point_z      (cur_pixel.z),
        .o_out_valid    (result_valid),
        .i_out_ready    (result_ready),
        .o_normal_valid (normal_valid),
        .o_normal_x     (normal_x),
        .o_normal_y     (normal_y),
        .o_normal_z     (normal_z)
    );

    // Free-running clock.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Cycle counter and run timeout.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("range_surface_normal_stream verification failed");
            $finish;
        end
    end

    // True inside the stretch where neither side idles.
    function automatic bit calm_window();
        return cycle_cnt >= CALM_START && cycle_cnt < CALM_END;
    endfunction

    // Random idle decision shared by both sides, off inside the calm window.
    function automatic bit take_break();
        if (calm_window()) return 1'b0;
        return $urandom_range(99) < 26;
    endfunction

    function automatic logic signed [OUT_W-1:0] sat_out(longint v);
        if (v > OUT_MAX) v = OUT_MAX;
        if (v < OUT_MIN) v = OUT_MIN;
        return v[OUT_W-1:0];
    endfunction

    // Moves the predictor to the start of the next line buffer row.
    function automatic void advance_row();
        col_cnt = 0;
        if (row_cnt < int'(ROW_MAX)) row_cnt++;
        row_slot = (row_slot + 1 >= NDIST) ? 0 : row_slot + 1;
    endfunction

    // Computes the normal for one pixel and updates the predictor's state.
    function automatic t_normal predict_normal(t_pixel px);
        t_normal res;
        t_point  up_pt;
        t_point  left_pt;
        longint  ax, ay, az, bx, by, bz;
        int      eff_w;
        int      base;
        bit      fg;
        eff_w = int'(width_shadow);
        if (eff_w > MAX_W) eff_w = MAX_W;
        if (eff_w < 1) eff_w = 1;
        if (px.frame_start) begin
            row_cnt  = 0;
            col_cnt  = 0;
            row_slot = 0;
        end
        if (col_cnt >= eff_w) advance_row();
        base = row_slot * MAX_W;
        fg = (px.range_value <= thr_shadow) && row_cnt >= NDIST && col_cnt >= NDIST;
        res = '0;
        // The buffer is read before this pixel's point replaces the old one.
        if (fg) begin
            up_pt   = line_store[base + col_cnt];
            left_pt = line_store[base + col_cnt - NDIST];
            ax = longint'(up_pt.x) - longint'(px.x);
            ay = longint'(up_pt.y) - longint'(px.y);
            az = longint'(up_pt.z) - longint'(px.z);
            bx = longint'(left_pt.x) - longint'(px.x);
            by = longint'(left_pt.y) - longint'(px.y);
            bz = longint'(left_pt.z) - longint'(px.z);
            res.valid = 1'b1;
            res.x = sat_out(ay * bz - az * by);
            res.y = sat_out(az * bx - ax * bz);
            res.z = sat_out(ax * by - ay * bx);
        end
        line_store[base + col_cnt].x = px.x;
        line_store[base + col_cnt].y = px.y;
        line_store[base + col_cnt].z = px.z;
        col_cnt++;
        if (col_cnt >= eff_w) advance_row();
        return res;
    endfunction

    // Pixel driver: predicts on each accepted transaction, then offers the next.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_valid <= 1'b0;
        end else begin
            if (pix_valid && pix_ready) begin
                normals_due.push_back(predict_normal(cur_pixel));
            end
            if (!pix_valid || pix_ready) begin
                if (pixel_queue.size() > 0 && !take_break()) begin
                    cur_pixel <= pixel_queue.pop_front();
                    pix_valid <= 1'b1;
                end else begin
                    pix_valid <= 1'b0;
                end
            end
        end
    end

    function automatic void check_field(string name, logic signed [63:0] expv,
                                        logic signed [63:0] actv);
        if (actv !== expv) begin
            $error("%s mismatch: expected %0d, got %0d", name, expv, actv);
            error_cnt++;
        end
    endfunction

    // Long receiver hold-offs, started only while plenty of pixels wait to be
    // offered so that the pipeline fills and stalls its input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (holds_done < 2 && checked_cnt >= 150 + 350 * holds_done &&
                     pixel_queue.size() > 40 && !calm_window()) begin
            hold_left  <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end
    end

    // Result monitor with random back-pressure.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_ready <= 1'b0;
        end else begin
            if (result_valid && result_ready) begin
                if (normals_due.size() == 0) begin
                    $error("normal transaction arrived with no pixel pending");
                    error_cnt++;
                end else begin
                    due_normal = normals_due.pop_front();
                    check_field("normal_valid", due_normal.valid, normal_valid);
                    check_field("normal_x", due_normal.x, normal_x);
                    check_field("normal_y", due_normal.y, normal_y);
                    check_field("normal_z", due_normal.z, normal_z);
                    if (due_normal.valid) fg_normal_cnt++;
                    checked_cnt++;
                end
            end
            if (hold_left > 0) begin
                result_ready <= 1'b0;
            end else begin
                result_ready <= !take_break();
            end
        end
    end

    // Writes one register once the channel accepts it.
    task automatic write_reg(input t_cfg_idx idx, input int value);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_W-1:0];
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_FG_THRESHOLD) thr_shadow = value[7:0];
        else width_shadow = value[CFG_W-1:0];
    endtask

    // Waits until every queued pixel has produced its checked result.
    task automatic drain();
        do @(negedge i_clk); while (checked_cnt != queued_cnt);
    endtask

    function automatic void push_pixel(t_pixel px);
        pixel_queue.push_back(px);
        queued_cnt++;
    endfunction

    function automatic logic signed [COORD_W-1:0] edge_coord(int k);
        case (k % 5)
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'h0001;
        endcase
    endfunction

    function automatic logic signed [COORD_W-1:0] rand_coord();
        if ($urandom_range(7) == 0) return edge_coord($urandom_range(4));
        return COORD_W'($urandom);
    endfunction

    // Random pixel with the range clustered around the current threshold.
    function automatic t_pixel rand_pixel(bit start);
        t_pixel px;
        px.frame_start = start;
        case ($urandom_range(5))
            0, 1:    px.range_value = 8'($urandom_range(255));
            2:       px.range_value = thr_shadow + 8'd1;
            3:       px.range_value = thr_shadow;
            default: px.range_value = 8'($urandom_range(thr_shadow));
        endcase
        px.x = rand_coord();
        px.y = rand_coord();
        px.z = rand_coord();
        return px;
    endfunction

    // Queues one stretch of raster pixels; noisy stretches restart the frame at random.
    task automatic queue_frame(input int len, input bit start, input bit noisy);
        @(negedge i_clk);
        for (int i = 0; i < len; i++) begin
            push_pixel(rand_pixel((start && i == 0) || (noisy && $urandom_range(299) == 0)));
        end
    endtask

    initial begin
        t_pixel px;
        int     w;
        int     weff;
        int     len;
        int     random_cnt;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed frame at width 4 and the reset threshold: extreme
        // points, the largest cross product, and ranges on both sides of the limit.
        write_reg(CFG_IMAGE_WIDTH, 4);
        @(negedge i_clk);
        for (int i = 0; i < 24; i++) begin
            px.frame_start = (i == 0);
            px.range_value = (i % 2 == 1) ? 8'd255 : 8'd0;
            px.x = edge_coord(3 * i);
            px.y = edge_coord(3 * i + 1);
            px.z = edge_coord(3 * i + 2);
            case (i)
                3:  begin px.x = 16'h7FFF; px.y = 16'h7FFF; px.z = 16'h8000; end
                12: begin px.x = 16'h8000; px.y = 16'h7FFF; px.z = 16'h7FFF; end
                15: begin px.x = 16'h8000; px.y = 16'h8000; px.z = 16'h7FFF;
                          px.range_value = 8'd0; end
                19: px.range_value = 8'd125;
                23: px.range_value = 8'd126;
                default: ;
            endcase
            push_pixel(px);
        end

        // Random frames over many widths and thresholds, with short broken frames.
        random_cnt = 0;
        while (random_cnt < RANDOM_ITEMS) begin
            case ($urandom_range(9))
                0:       w = $urandom_range(3);
                1:       w = $urandom_range(96, 40);
                default: w = $urandom_range(24, 4);
            endcase
            weff = (w == 0) ? 1 : w;
            drain();
            case ($urandom_range(4))
                0:       write_reg(CFG_FG_THRESHOLD, 0);
                1:       write_reg(CFG_FG_THRESHOLD, 255);
                default: write_reg(CFG_FG_THRESHOLD, $urandom_range(255));
            endcase
            write_reg(CFG_IMAGE_WIDTH, w);
            repeat ($urandom_range(2, 1)) begin
                if ($urandom_range(5) == 0) len = $urandom_range(3 * weff, 1);
                else len = $urandom_range(7, 4) * weff + $urandom_range(weff - 1);
                // The last frame is cut short to keep the pixel budget.
                if (len > RANDOM_ITEMS - random_cnt) len = RANDOM_ITEMS - random_cnt;
                if (len > 0) begin
                    queue_frame(len, 1'b1, 1'b1);
                    random_cnt += len;
                end
            end
        end

        // Width shrinks within a frame: first past the current column, then not.
        drain();
        write_reg(CFG_FG_THRESHOLD, 255);
        write_reg(CFG_IMAGE_WIDTH, 20);
        queue_frame(20 * 5 + 7, 1'b1, 1'b0);
        drain();
        write_reg(CFG_IMAGE_WIDTH, 6);
        queue_frame(32, 1'b0, 1'b0);
        drain();
        write_reg(CFG_IMAGE_WIDTH, 5);
        queue_frame(20, 1'b0, 1'b0);

        // An oversized width that must clamp to the line length.
        drain();
        write_reg(CFG_IMAGE_WIDTH, 2047);
        queue_frame(30, 1'b1, 1'b0);

        drain();
        repeat (20) @(posedge i_clk);
        $display("Checked %0d pixel transactions, %0d of them with a computed normal.",
                 checked_cnt, fg_normal_cnt);
        $display("Widths 0 to 2047, thresholds 0 to 255, mid-frame shrink, long stalls.");
        if (error_cnt == 0) begin
            $display("range_surface_normal_stream verification clean");
        end else begin
            $display("range_surface_normal_stream verification failed");
        end
        $finish;
    end

endmodule
